### rtl/core/plm_pkg.sv
// Shared types, constants and helpers of the Poly1305 authenticator.
package plm_pkg;

  localparam int LimbW = 26;
  localparam int AccW  = 27;
  localparam logic [63:0] ClampLo = 64'h0ffffffc0fffffff;
  localparam logic [63:0] ClampHi = 64'h0ffffffc0ffffffc;

  // Key register indexes on the configuration port.
  localparam logic [1:0] RegRLow  = 2'd0;
  localparam logic [1:0] RegRHigh = 2'd1;
  localparam logic [1:0] RegSLow  = 2'd2;
  localparam logic [1:0] RegSHigh = 2'd3;

  typedef logic [4:0][LimbW-1:0] limbs_t;

  // One classified block handed from the front end to the multiply engine.
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        top;
    logic        absorb;
    logic        last;
  } entry_t;

  // Splits a 129-bit value into five base 2^26 limbs.
  function automatic limbs_t split_limbs(logic [63:0] lo, logic [63:0] hi, logic top);
    limbs_t l;
    l[0] = lo[25:0];
    l[1] = lo[51:26];
    l[2] = {hi[13:0], lo[63:52]};
    l[3] = hi[39:14];
    l[4] = {1'b0, top, hi[63:40]};
    return l;
  endfunction

endpackage

### rtl/core/plm_front.sv
// Front end: takes input words, pads partial blocks and classifies them.
module plm_front (
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [63:0]        blk_lo_i,
  input  logic [63:0]        blk_hi_i,
  input  logic [4:0]         byte_count_i,
  input  logic               is_last_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output plm_pkg::entry_t    q_entry_o
);
  import plm_pkg::*;

  logic [5:0]  sh;
  logic [63:0] mask;
  logic [63:0] one_bit;

  assign s_tready_o = !q_full_i;
  assign q_push_o   = s_tvalid_i && !q_full_i;

  always_comb begin
    sh      = {byte_count_i[2:0], 3'b000};
    mask    = (64'd1 << sh) - 64'd1;
    one_bit = 64'd1 << sh;
    q_entry_o.last   = is_last_i;
    q_entry_o.lo     = blk_lo_i;
    q_entry_o.hi     = blk_hi_i;
    q_entry_o.top    = 1'b0;
    q_entry_o.absorb = 1'b1;
    if (byte_count_i >= 5'd16) begin
      q_entry_o.top = 1'b1;
    end else if (byte_count_i == 5'd0) begin
      q_entry_o.absorb = 1'b0;
    end else if (byte_count_i < 5'd8) begin
      // The 0x01 pad byte lands right after the last valid byte.
      q_entry_o.lo = (blk_lo_i & mask) | one_bit;
      q_entry_o.hi = 64'd0;
    end else begin
      q_entry_o.hi = (blk_hi_i & mask) | one_bit;
    end
  end

endmodule

### rtl/core/plm_fifo.sv
// Two-word queue between the front end and the multiply engine.
module plm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  plm_pkg::entry_t din_i,
  input  logic            pop_i,
  output plm_pkg::entry_t dout_o,
  output logic            full_o,
  output logic            empty_o
);
  import plm_pkg::*;

  entry_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign dout_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### rtl/core/plm_core.sv
// Multiply engine: limb-serial (acc + m) * r mod 2^130-5 and tag finalization.
module plm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [63:0]     r_lo_i,
  input  logic [63:0]     r_hi_i,
  input  logic [63:0]     s_lo_i,
  input  logic [63:0]     s_hi_i,
  input  logic            q_empty_i,
  input  plm_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  output logic [127:0]    tag_o
);
  import plm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CARRY = 3'd2;
  localparam logic [2:0] S_FIN1  = 3'd3;
  localparam logic [2:0] S_FIN2  = 3'd4;

  logic [2:0]        st_q, st_d;
  logic [2:0]        j_q;
  logic              last_q;
  logic [AccW-1:0]   acc_q [5];
  logic [AccW:0]     a_q [5];
  logic [LimbW-1:0]  r_q [5];
  logic [LimbW+2:0]  s5_q [5];
  logic [63:0]       d_q [5];
  logic [AccW-1:0]   h_q [5];
  logic              ov_q;
  logic [127:0]      tag_q;

  limbs_t            m_l, r_l;
  logic [LimbW+2:0]  opnd [10];
  logic [63:0]       prod [5];
  logic [3:0]        k5;
  logic [63:0]       t, c;
  logic [AccW-1:0]   nacc [5];
  logic [63:0]       h [5];
  logic [63:0]       g [5];
  logic [63:0]       cg;
  logic [63:0]       lo, hi, sum_lo;
  logic              out_free;

  assign q_pop_o    = (st_q == S_IDLE) && !q_empty_i;
  assign m_tvalid_o = ov_q;
  assign tag_o      = tag_q;
  assign out_free   = !ov_q || m_tready_i;

  always_comb begin
    m_l = split_limbs(q_entry_i.lo, q_entry_i.hi, q_entry_i.top);
    r_l = split_limbs(r_lo_i & ClampLo, r_hi_i & ClampHi, 1'b0);
    // Entries 0..4 hold 5*r (wrapped terms), 5..9 hold r.
    for (int i = 0; i < 5; i++) begin
      opnd[i]   = s5_q[i];
      opnd[i+5] = {3'b000, r_q[i]};
    end
    for (int i = 0; i < 5; i++) begin
      k5      = 4'(i + 5) - {1'b0, j_q};
      prod[i] = 64'(a_q[j_q]) * 64'(opnd[k5]);
    end
  end

  // Carry propagation after the multiply, as a partial reduction.
  always_comb begin
    c = 64'd0;
    for (int i = 0; i < 5; i++) begin
      t       = d_q[i] + c;
      c       = t >> 26;
      nacc[i] = AccW'(t[25:0]);
    end
    t       = {37'd0, nacc[0]} + c + (c << 2);
    c       = t >> 26;
    nacc[0] = AccW'(t[25:0]);
    nacc[1] = nacc[1] + AccW'(c);
  end

  // Final full reduction, conditional subtraction of p, and addition of s.
  always_comb begin
    for (int i = 0; i < 5; i++) h[i] = 64'(h_q[i]);
    cg = 64'd5;
    for (int i = 0; i < 5; i++) begin
      g[i] = h[i] + cg;
      cg   = g[i] >> 26;
      g[i] = g[i] & 64'h3ffffff;
    end
    if (cg != 64'd0) begin
      for (int i = 0; i < 5; i++) h[i] = g[i];
    end
    lo     = h[0] | (h[1] << 26) | (h[2] << 52);
    hi     = (h[2] >> 12) | (h[3] << 14) | (h[4] << 40);
    sum_lo = lo + s_lo_i;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          if (q_entry_i.absorb) st_d = S_MUL;
          else if (q_entry_i.last) st_d = S_FIN1;
        end
      end
      S_MUL:   if (j_q == 3'd4) st_d = S_CARRY;
      S_CARRY: st_d = last_q ? S_FIN1 : S_IDLE;
      S_FIN1:  st_d = S_FIN2;
      S_FIN2:  if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ov_q   <= 1'b0;
      j_q    <= 3'd0;
      last_q <= 1'b0;
      for (int i = 0; i < 5; i++) acc_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == S_FIN2 && out_free) ov_q <= 1'b1;
      else if (ov_q && m_tready_i) ov_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            last_q <= q_entry_i.last;
            j_q    <= 3'd0;
          end
        end
        S_MUL:   j_q <= j_q + 3'd1;
        S_CARRY: for (int i = 0; i < 5; i++) acc_q[i] <= nacc[i];
        S_FIN2: begin
          if (out_free) begin
            for (int i = 0; i < 5; i++) acc_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && !q_empty_i) begin
      for (int i = 0; i < 5; i++) begin
        a_q[i]  <= {1'b0, acc_q[i]} + (AccW+1)'(m_l[i]);
        r_q[i]  <= r_l[i];
        s5_q[i] <= (LimbW+3)'(r_l[i]) * (LimbW+3)'(5);
        d_q[i]  <= 64'd0;
      end
    end else if (st_q == S_MUL) begin
      for (int i = 0; i < 5; i++) d_q[i] <= d_q[i] + prod[i];
    end
    if (st_q == S_FIN1) begin
      // Carry the limbs from one upward, fold the top carry back times five.
      begin
        logic [63:0] hh [5];
        logic [63:0] cc;
        for (int i = 0; i < 5; i++) hh[i] = 64'(acc_q[i]);
        cc = 64'd0;
        for (int i = 1; i < 5; i++) begin
          hh[i] = hh[i] + cc;
          cc    = hh[i] >> 26;
          hh[i] = hh[i] & 64'h3ffffff;
        end
        hh[0] = hh[0] + cc + (cc << 2);
        cc    = hh[0] >> 26;
        hh[0] = hh[0] & 64'h3ffffff;
        hh[1] = hh[1] + cc;
        cc    = hh[1] >> 26;
        hh[1] = hh[1] & 64'h3ffffff;
        hh[2] = hh[2] + cc;
        for (int i = 0; i < 5; i++) h_q[i] <= AccW'(hh[i]);
      end
    end
    if (st_q == S_FIN2 && out_free) begin
      tag_q <= {hi + s_hi_i + {63'd0, sum_lo < lo}, sum_lo};
    end
  end

endmodule

### rtl/core/poly1305_mac.sv
// Top level of the Poly1305 authenticator.
// Each 16-byte word runs through a limb-serial multiplier between a fetch step
// and a carry step; a last word then passes final reduction and tag formation.
// A zero-count word that is not last is only dequeued. Keys are written through
// the cfg port (0: r low, 1: r high, 2: s low, 3: s high); the user must write
// them only while the block is idle; the block does not enforce this. r is
// clamped on use. A two-word queue lets the input side keep accepting while the
// multiplier is busy, and the tag sits in an output register until taken.
module poly1305_mac (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // block_low [63:0], block_high [127:64], byte_count [132:128], zero fill
  input  logic [135:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tag_low [63:0], tag_high [127:64]
  output logic [127:0] m_axis_tdata_o
);
  import plm_pkg::*;

  logic [63:0] r_lo_q, r_hi_q, s_lo_q, s_hi_q;
  logic        q_push, q_pop, q_full, q_empty;
  entry_t      q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_lo_q <= '0;
      r_hi_q <= '0;
      s_lo_q <= '0;
      s_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRLow:  r_lo_q <= cfg_data_i;
        RegRHigh: r_hi_q <= cfg_data_i;
        RegSLow:  s_lo_q <= cfg_data_i;
        RegSHigh: s_hi_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  plm_front u_front (
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_o   (s_axis_tready_o),
    .blk_lo_i     (s_axis_tdata_i[63:0]),
    .blk_hi_i     (s_axis_tdata_i[127:64]),
    .byte_count_i (s_axis_tdata_i[132:128]),
    .is_last_i    (s_axis_tlast_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_in)
  );

  plm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_in),
    .pop_i   (q_pop),
    .dout_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  plm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .r_lo_i     (r_lo_q),
    .r_hi_i     (r_hi_q),
    .s_lo_i     (s_lo_q),
    .s_hi_i     (s_hi_q),
    .q_empty_i  (q_empty),
    .q_entry_i  (q_out),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .tag_o      (m_axis_tdata_o)
  );

endmodule

### rtl/core/plm_checker.sv
// Port-level checks for the Poly1305 authenticator, bound to the top level.
module plm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         s_axis_tlast_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o
);

  logic [2:0] pend_q;
  logic       in_last, out_take;

  assign in_last  = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign out_take = m_axis_tvalid_o && m_axis_tready_i;

  // Last words accepted whose tag has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 3'd0;
    else pend_q <= pend_q + {2'd0, in_last} - {2'd0, out_take};
  end

  a_no_spurious_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 3'd0)
    else $error("tag shown without a pending last word");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("too many last words in flight");

  a_tag_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled tag changed");

endmodule

bind poly1305_mac plm_checker u_plm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

### tb/sv/poly1305_mac_tb.sv
// Self-checking testbench of the Poly1305 authenticator with an exact-arithmetic tag predictor.
`timescale 1ns / 1ps

module poly1305_mac_tb;
  import plm_pkg::*;

  localparam int unsigned SettleCycles = 40;
  localparam logic [263:0] PrimeP = (264'h1 << 130) - 264'd5;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = RegRLow;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [135:0] s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;

  poly1305_mac dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: keys as written and the accumulator, always fully reduced.
  logic [63:0]  key_r_lo, key_r_hi, key_s_lo, key_s_hi;
  logic [129:0] acc_val;
  logic [127:0] tag_queue[$];
  int unsigned  fail_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  function automatic logic [129:0] absorb_block(logic [129:0] acc, logic [63:0] lo,
                                                logic [63:0] hi, logic [4:0] cnt);
    logic [129:0] m;
    logic [127:0] mask;
    logic [263:0] prod;
    logic [127:0] r_clamped;
    int unsigned  nbits;
    r_clamped = {key_r_hi & plm_pkg::ClampHi, key_r_lo & plm_pkg::ClampLo};
    if (cnt == 5'd0) return acc;
    if (cnt >= 5'd16) begin
      m = {2'b01, hi, lo};
    end else begin
      nbits = cnt * 8;
      mask = (128'h1 << nbits) - 128'h1;
      m = {2'b00, ({hi, lo} & mask) | (128'h1 << nbits)};
    end
    prod = (264'(acc) + 264'(m)) * 264'(r_clamped);
    return 130'(prod % PrimeP);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      RegRLow:  key_r_lo = val;
      RegRHigh: key_r_hi = val;
      RegSLow:  key_s_lo = val;
      default:  key_s_hi = val;
    endcase
  endtask

  task automatic wait_idle();
    while (tag_queue.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic load_keys(logic [63:0] rl, logic [63:0] rh, logic [63:0] sl, logic [63:0] sh);
    wait_idle();
    write_reg(RegRLow, rl);
    write_reg(RegRHigh, rh);
    write_reg(RegSLow, sl);
    write_reg(RegSHigh, sh);
  endtask

  // Drives one word; returns after it is accepted with tvalid still high.
  task automatic send_block(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {3'b000, cnt, hi, lo};
    s_axis_tlast_i = last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    acc_val = absorb_block(acc_val, lo, hi, cnt);
    if (last) begin
      tag_queue.push_back(128'(acc_val) + {key_s_hi, key_s_lo});
      acc_val = '0;
    end
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    s_axis_tvalid_i = 1'b0;
  endtask

  always @(negedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (tag_queue.size() == 0) begin
        $display("%0t: unexpected tag, expected none, actual %h", $time, m_axis_tdata_o);
        fail_count++;
      end else begin
        if (m_axis_tdata_o[63:0] !== tag_queue[0][63:0]) begin
          $display("%0t: tag_low mismatch, expected %h, actual %h", $time,
                   tag_queue[0][63:0], m_axis_tdata_o[63:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[127:64] !== tag_queue[0][127:64]) begin
          $display("%0t: tag_high mismatch, expected %h, actual %h", $time,
                   tag_queue[0][127:64], m_axis_tdata_o[127:64]);
          fail_count++;
        end
        void'(tag_queue.pop_front());
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    load_keys(ones, ones, ones, ones);
    send_block(ones, ones, 5'd16, 1'b0);
    send_block(ones, ones, 5'd31, 1'b0);
    send_block(ones, ones, 5'd15, 1'b1);
    send_block(ones, ones, 5'd0, 1'b1);   // empty message gives s alone
    send_block(ones, ones, 5'd1, 1'b0);   // partial word that is not last
    send_block(ones, ones, 5'd0, 1'b0);   // zero count, not last
    send_block(ones, ones, 5'd7, 1'b1);
    send_block(ones, ones, 5'd8, 1'b1);
    send_block(ones, ones, 5'd9, 1'b1);
    send_block(ones, ones, 5'd17, 1'b1);
    end_burst();
    load_keys('0, '0, '0, '0);
    send_block(ones, ones, 5'd16, 1'b0);
    send_block('0, '0, 5'd16, 1'b1);
    end_burst();
    load_keys(rand64(), rand64(), rand64(), rand64());
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd3, 1'b0);
    send_block(rand64(), rand64(), 5'd12, 1'b1);
    send_block('0, '0, 5'd0, 1'b0);
    send_block(ones, '0, 5'd16, 1'b1);
    end_burst();
  endtask

  task automatic test_random(int unsigned idle_pct, int unsigned stall_pct, int unsigned n_items);
    int unsigned sent, n_full, k;
    logic [4:0] cnt;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        end_burst();
        case ($urandom_range(3))
          0: load_keys('1, '1, '1, '1);
          1: load_keys('0, '0, rand64(), rand64());
          default: load_keys(rand64(), rand64(), rand64(), rand64());
        endcase
      end
      if ($urandom_range(9) == 0) begin
        // Noise: odd counts, partial words mid-message, idle words.
        cnt = 5'($urandom_range(31));
        send_block(rand64(), rand64(), cnt, 1'b0);
        sent++;
      end
      n_full = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(3);
      for (k = 0; k < n_full; k++) begin
        send_block(rand64(), rand64(), ($urandom_range(7) == 0) ? 5'd31 : 5'd16, 1'b0);
        sent++;
      end
      send_block(rand64(), rand64(), 5'($urandom_range(16)), 1'b1);
      sent++;
      if ($urandom_range(15) == 0) begin
        end_burst();
        while (tag_queue.size() != 0) @(negedge clk_i);
      end
    end
    end_burst();
  endtask

  initial begin
    key_r_lo = '0;
    key_r_hi = '0;
    key_s_lo = '0;
    key_s_hi = '0;
    acc_val = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(0, 0, 280);
    test_random(57, 0, 280);
    test_random(0, 57, 280);
    test_random(23, 23, 280);
    while (tag_queue.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
rtl/core/plm_pkg.sv
rtl/core/plm_front.sv
rtl/core/plm_fifo.sv
rtl/core/plm_core.sv
rtl/core/poly1305_mac.sv
rtl/core/plm_checker.sv
tb/sv/poly1305_mac_tb.sv
